// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ETQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ETQ_ASSERT_ANY(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ETQ_ASSERT(lbl, clk, rst_n, prop)
`define ETQ_ASSERT_ANY(lbl, clk, prop)
`endif
`endif

// ===== sv/etq_pkg.sv =====
`timescale 1ns / 1ps
package etq_pkg;

    localparam int ANGLE_WIDTH = 16;
    localparam int QUAT_WIDTH  = 16;
    localparam int IFRAC       = 30;
    // pipeline depth of one sine/cosine lane, input to registered output
    localparam int SC_STAGES   = 31;

    typedef logic signed [32:0] t_q30;

    localparam t_q30 ONE_Q = t_q30'(64'd1 << IFRAC);
    localparam logic signed [34:0] PI_Q      = 35'sd3373259426;
    localparam logic signed [34:0] HALF_PI_Q = 35'sd1686629713;

    typedef struct packed {
        logic signed [ANGLE_WIDTH-1:0] roll_angle;
        logic signed [ANGLE_WIDTH-1:0] pitch_angle;
        logic signed [ANGLE_WIDTH-1:0] yaw_angle;
    } t_angles;

    typedef struct packed {
        logic signed [QUAT_WIDTH-1:0] quat_x;
        logic signed [QUAT_WIDTH-1:0] quat_y;
        logic signed [QUAT_WIDTH-1:0] quat_z;
        logic signed [QUAT_WIDTH-1:0] quat_w;
    } t_quat;

    // Q60 product back to Q30, round to nearest, ties away from zero
    function automatic t_q30 rnd_q30(input logic signed [65:0] v);
        logic [65:0] mag;
        logic [65:0] r;
        begin
            mag = v[65] ? 66'(-v) : 66'(v);
            r = (mag + (66'd1 << (IFRAC - 1))) >> IFRAC;
            rnd_q30 = v[65] ? -$signed(r[32:0]) : $signed(r[32:0]);
        end
    endfunction

endpackage

// ===== sv/etq_step.sv =====
`timescale 1ns / 1ps
// One Horner step: t_out = 1 - trunc(round(x2 * t) / D), three stages.
module etq_step import etq_pkg::*; #(
    parameter int D   = 6,
    parameter int SBW = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  t_q30           i_x2,
    input  t_q30           i_t,
    input  logic [SBW-1:0] i_sb,
    output logic           o_vld,
    output t_q30           o_x2,
    output t_q30           o_t,
    output logic [SBW-1:0] o_sb
);

    // reciprocal estimate is low by at most one, fixed by one compare
    localparam int SH = 31 + $clog2(D);
    localparam logic [63:0] MUL64 = (64'd1 << SH) / 64'(D);
    localparam logic [31:0] MUL = MUL64[31:0];
    localparam logic [40:0] DC = 41'(D);

    logic signed [65:0] r_a;
    logic [31:0]        r_mag;
    logic               r_neg;
    logic [63:0]        r_mq;
    logic [2:0]         r_vld;
    t_q30               r_x2 [3];
    logic [SBW-1:0]     r_sb [3];
    t_q30               r_t;

    t_q30        w_p;
    logic [31:0] w_mag;
    logic [31:0] w_q0;
    logic [40:0] w_rem;
    logic [31:0] w_q;
    t_q30        w_qs;

    always_comb begin
        w_p   = rnd_q30(r_a);
        w_mag = w_p[32] ? 32'(-w_p) : w_p[31:0];
        w_q0  = 32'(r_mq >> SH);
        w_rem = 41'(r_mag) - 41'(w_q0) * DC;
        w_q   = (w_rem >= DC) ? w_q0 + 32'd1 : w_q0;
        w_qs  = r_neg ? -$signed({1'b0, w_q}) : $signed({1'b0, w_q});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= 66'(i_x2) * 66'(i_t);
        r_mag <= w_mag;
        r_neg <= w_p[32];
        r_mq  <= 64'(w_mag) * 64'(MUL);
        r_t   <= ONE_Q - w_qs;
        r_x2[0] <= i_x2;
        r_x2[1] <= r_x2[0];
        r_x2[2] <= r_x2[1];
        r_sb[0] <= i_sb;
        r_sb[1] <= r_sb[0];
        r_sb[2] <= r_sb[1];
    end

    assign o_vld = r_vld[2];
    assign o_x2  = r_x2[2];
    assign o_t   = r_t;
    assign o_sb  = r_sb[2];

endmodule

// ===== sv/etq_sincos.sv =====
`timescale 1ns / 1ps
// Sine and cosine of minus half an angle, Q30.
module etq_sincos import etq_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic signed [ANGLE_WIDTH-1:0] i_angle,
    output logic                          o_vld,
    output t_q30                          o_sin,
    output t_q30                          o_cos
);

    localparam int SSTEPS = 8;
    localparam int CSTEPS = 9;

    // fold stage
    logic signed [34:0] w_aext;
    logic signed [34:0] w_th;
    logic signed [34:0] w_fold;
    logic               w_flip;
    logic [30:0]        r_x;
    logic               r_neg;
    logic               r_flip;
    logic [2:0]         r_vld;
    logic [61:0]        r_xx;
    logic [30:0]        r_x1;
    logic               r_neg1;
    logic               r_flip1;
    t_q30               r_x2;
    logic [32:0]        r_sb2;

    always_comb begin
        w_aext = 35'(i_angle);
        w_th   = (-w_aext) <<< (33 - ANGLE_WIDTH);
        w_fold = w_th;
        w_flip = 1'b0;
        if (w_th > HALF_PI_Q) begin
            w_fold = w_th - PI_Q;
            w_flip = 1'b1;
        end else if (w_th < -HALF_PI_Q) begin
            w_fold = w_th + PI_Q;
            w_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= w_fold[34] ? 31'(-w_fold) : w_fold[30:0];
        r_neg   <= w_fold[34];
        r_flip  <= w_flip;
        r_xx    <= 62'(r_x) * 62'(r_x);
        r_x1    <= r_x;
        r_neg1  <= r_neg;
        r_flip1 <= r_flip;
        r_x2    <= $signed({1'b0, 32'((r_xx + (62'd1 << (IFRAC - 1))) >> IFRAC)});
        r_sb2   <= {r_flip1, r_neg1, r_x1};
    end

    // Horner chains
    logic        w_sv  [SSTEPS+1];
    t_q30        w_sx2 [SSTEPS+1];
    t_q30        w_st  [SSTEPS+1];
    logic [32:0] w_ssb [SSTEPS+1];
    logic        w_cv  [CSTEPS+1];
    t_q30        w_cx2 [CSTEPS+1];
    t_q30        w_ct  [CSTEPS+1];
    logic [0:0]  w_csb [CSTEPS+1];

    assign w_sv[0]  = r_vld[2];
    assign w_sx2[0] = r_x2;
    assign w_st[0]  = ONE_Q;
    assign w_ssb[0] = r_sb2;
    assign w_cv[0]  = r_vld[2];
    assign w_cx2[0] = r_x2;
    assign w_ct[0]  = ONE_Q;
    assign w_csb[0] = r_sb2[32];

    for (genvar j = 0; j < SSTEPS; j++) begin : g_sin
        etq_step #(.D((16 - 2 * j) * (17 - 2 * j)), .SBW(33)) u_step (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_vld(w_sv[j]), .i_x2(w_sx2[j]), .i_t(w_st[j]), .i_sb(w_ssb[j]),
            .o_vld(w_sv[j+1]), .o_x2(w_sx2[j+1]), .o_t(w_st[j+1]), .o_sb(w_ssb[j+1])
        );
    end

    for (genvar j = 0; j < CSTEPS; j++) begin : g_cos
        etq_step #(.D((17 - 2 * j) * (18 - 2 * j)), .SBW(1)) u_step (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_vld(w_cv[j]), .i_x2(w_cx2[j]), .i_t(w_ct[j]), .i_sb(w_csb[j]),
            .o_vld(w_cv[j+1]), .o_x2(w_cx2[j+1]), .o_t(w_ct[j+1]), .o_sb(w_csb[j+1])
        );
    end

    // sine tail: multiply by x, round and sign, then hold to meet cosine
    logic signed [65:0] r_sxt;
    logic               r_sflip;
    t_q30               r_s29;
    t_q30               r_s30;
    t_q30               w_sr;
    logic               r_vo;
    t_q30               r_sin;
    t_q30               r_cos;

    assign w_sr = rnd_q30(r_sxt);

    always_ff @(posedge i_clk) begin
        r_sxt   <= 66'($signed({1'b0, w_ssb[SSTEPS][30:0]})) * 66'(w_st[SSTEPS]);
        r_sflip <= w_ssb[SSTEPS][32] ^ w_ssb[SSTEPS][31];
        r_s29   <= r_sflip ? -w_sr : w_sr;
        r_s30   <= r_s29;
        r_sin   <= r_s30;
        r_cos   <= w_csb[CSTEPS][0] ? -w_ct[CSTEPS] : w_ct[CSTEPS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else begin
            r_vo <= w_cv[CSTEPS];
        end
    end

    assign o_vld = r_vo;
    assign o_sin = r_sin;
    assign o_cos = r_cos;

    `include "assert_macros.svh"
    `ETQ_ASSERT(a_chain_align, i_clk, i_rst_n, o_vld |-> $past(w_sv[SSTEPS], 4))
    `ETQ_ASSERT(a_sin_cos_vld, i_clk, i_rst_n, w_cv[CSTEPS] |-> $past(w_sv[SSTEPS], 3))
    `ETQ_ASSERT(a_vo_follow, i_clk, i_rst_n, r_vo |-> $past(i_vld, SC_STAGES))

endmodule

// ===== sv/euler_to_quaternion_core.sv =====
`timescale 1ns / 1ps
// Channel  | Ports                      | Beat
// ---------+----------------------------+-----------------------------------
// command  | start, busy, i_angles      | start high with busy low
// result   | o_valid, o_quat            | o_valid high for one cycle
//
// One beat enters every cycle and busy stays low.
// Depth is set by the nine-step cosine Horner chain, three stages per step
// (product, reciprocal multiply, correct), then five product/round stages.
// Reset is synchronous, active low, and clears only the valid bits.
// The receiver cannot stall; every result shows for exactly one cycle.
module euler_to_quaternion_core import etq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_angles i_angles,
    output logic    o_valid,
    output t_quat   o_quat
);

    localparam int LATENCY = 1 + SC_STAGES + 5;
    localparam int FS      = 2 * IFRAC - (QUAT_WIDTH - 2);
    localparam int QLIM    = 1 << (QUAT_WIDTH - 2);
    localparam logic [66:0] LIM = 67'd1 << (QUAT_WIDTH - 2);

    // the pipeline never holds, so the command side is always open
    assign busy = 1'b0;

    // capture the beat
    logic    r_vld0;
    t_angles r_ang;

    always_ff @(posedge i_clk) begin
        r_ang <= i_angles;
    end

    // three trig lanes, one per angle
    logic w_vld [3];
    t_q30 w_sin [3];
    t_q30 w_cos [3];

    etq_sincos u_roll (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_vld0), .i_angle(r_ang.roll_angle),
        .o_vld(w_vld[0]), .o_sin(w_sin[0]), .o_cos(w_cos[0])
    );
    etq_sincos u_pitch (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_vld0), .i_angle(r_ang.pitch_angle),
        .o_vld(w_vld[1]), .o_sin(w_sin[1]), .o_cos(w_cos[1])
    );
    etq_sincos u_yaw (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_vld0), .i_angle(r_ang.yaw_angle),
        .o_vld(w_vld[2]), .o_sin(w_sin[2]), .o_cos(w_cos[2])
    );

    // P1: roll-pitch pair products; hold yaw trig alongside
    // pair order: sr*cp, cr*sp, cr*cp, sr*sp
    logic signed [65:0] r_pair [4];
    t_q30               r_sy1, r_cy1;
    // P2: pairs back to Q30
    t_q30               r_pq [4];
    t_q30               r_sy2, r_cy2;
    // P3: eight triple products, Q60
    logic signed [65:0] r_tri [8];
    // P4: component sums
    logic signed [66:0] r_sum [4];
    // P5: output, driven straight onto the result ports
    logic [3:0]         r_vld;
    t_quat              r_quat;

    logic signed [QUAT_WIDTH-1:0] w_comp [4];

    always_comb begin
        logic [66:0] mag;
        logic [66:0] rr;
        logic [QUAT_WIDTH-1:0] val;
        for (int i = 0; i < 4; i++) begin
            mag = r_sum[i][66] ? 67'(-r_sum[i]) : 67'(r_sum[i]);
            rr = (mag + (67'd1 << (FS - 1))) >> FS;
            if (rr > LIM) begin
                rr = LIM;
            end
            val = rr[QUAT_WIDTH-1:0];
            w_comp[i] = r_sum[i][66] ? -$signed(val) : $signed(val);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pair[0] <= 66'(w_sin[0]) * 66'(w_cos[1]);
        r_pair[1] <= 66'(w_cos[0]) * 66'(w_sin[1]);
        r_pair[2] <= 66'(w_cos[0]) * 66'(w_cos[1]);
        r_pair[3] <= 66'(w_sin[0]) * 66'(w_sin[1]);
        r_sy1 <= w_sin[2];
        r_cy1 <= w_cos[2];
        for (int i = 0; i < 4; i++) begin
            r_pq[i] <= rnd_q30(r_pair[i]);
        end
        r_sy2 <= r_sy1;
        r_cy2 <= r_cy1;
        r_tri[0] <= 66'(r_pq[0]) * 66'(r_cy2);
        r_tri[1] <= 66'(r_pq[1]) * 66'(r_sy2);
        r_tri[2] <= 66'(r_pq[1]) * 66'(r_cy2);
        r_tri[3] <= 66'(r_pq[0]) * 66'(r_sy2);
        r_tri[4] <= 66'(r_pq[2]) * 66'(r_sy2);
        r_tri[5] <= 66'(r_pq[3]) * 66'(r_cy2);
        r_tri[6] <= 66'(r_pq[2]) * 66'(r_cy2);
        r_tri[7] <= 66'(r_pq[3]) * 66'(r_sy2);
        r_sum[0] <= 67'(r_tri[0]) - 67'(r_tri[1]);
        r_sum[1] <= 67'(r_tri[2]) + 67'(r_tri[3]);
        r_sum[2] <= 67'(r_tri[4]) - 67'(r_tri[5]);
        r_sum[3] <= 67'(r_tri[6]) + 67'(r_tri[7]);
        r_quat.quat_x <= w_comp[0];
        r_quat.quat_y <= w_comp[1];
        r_quat.quat_z <= w_comp[2];
        r_quat.quat_w <= w_comp[3];
    end

    // valid bits: advance every cycle, drop on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_vld  <= '0;
        end else begin
            r_vld0 <= start && !busy;
            r_vld  <= {r_vld[2:0], w_vld[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_vld[3];
        end
    end

    assign o_quat = r_quat;

    `include "assert_macros.svh"
    `ETQ_ASSERT(a_lanes_aligned, i_clk, i_rst_n, (w_vld[0] == w_vld[1]) && (w_vld[0] == w_vld[2]))
    `ETQ_ASSERT(a_latency, i_clk, i_rst_n, o_valid |-> $past(start && !busy, LATENCY))
    `ETQ_ASSERT(a_w_bound, i_clk, i_rst_n, o_valid |-> ((o_quat.quat_w <= QLIM) && (o_quat.quat_w >= -QLIM)))
    `ETQ_ASSERT_ANY(a_never_busy, i_clk, !busy || !i_rst_n)

endmodule

// ===== tb/sv/quat_checker.sv =====
`timescale 1ns / 1ps
module quat_checker import etq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_busy,
    input  t_angles i_angles,
    input  logic    i_valid,
    input  t_quat   i_quat,
    output int      o_fail_count,
    output int      o_pending
);

    // Expected quaternions, oldest first.
    t_quat quat_fifo[$];

    localparam longint ONE  = 64'sd1 << 30;
    localparam longint PI   = 64'sd3373259426;
    localparam longint HPI  = 64'sd1686629713;

    function automatic longint rnd_shift(longint v, int s);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'sd1 << (s - 1))) >>> s;
        return (v < 0) ? -mag : mag;
    endfunction

    // Sine and cosine (Q30) of minus half the angle.
    function automatic void half_trig(input logic signed [15:0] ang, output longint sn,
                                      output longint cs);
        longint th, x, x2, t;
        bit flip, neg;
        flip = 0;
        th = -longint'(ang) * (64'sd1 << (33 - ANGLE_WIDTH));
        if (th > HPI) begin
            th -= PI;
            flip = 1;
        end else if (th < -HPI) begin
            th += PI;
            flip = 1;
        end
        neg = th < 0;
        x = neg ? -th : th;
        x2 = rnd_shift(x * x, 30);
        t = ONE;
        for (int k = 8; k >= 1; k--) t = ONE - rnd_shift(x2 * t, 30) / longint'(2*k*(2*k+1));
        sn = rnd_shift(x * t, 30);
        if (neg) sn = -sn;
        t = ONE;
        for (int k = 9; k >= 1; k--) t = ONE - rnd_shift(x2 * t, 30) / longint'((2*k-1)*(2*k));
        cs = flip ? -t : t;
        if (flip) sn = -sn;
    endfunction

    function automatic longint prod3(longint a, longint b, longint c);
        return rnd_shift(a * b, 30) * c;
    endfunction

    function automatic logic signed [15:0] to_q14(longint q60);
        longint v;
        v = rnd_shift(q60, 46);
        if (v > 16384) v = 16384;
        if (v < -16384) v = -16384;
        return v[15:0];
    endfunction

    function automatic t_quat euler_quat(t_angles a);
        longint sr, cr, sp, cp, sy, cy;
        t_quat q;
        half_trig(a.roll_angle, sr, cr);
        half_trig(a.pitch_angle, sp, cp);
        half_trig(a.yaw_angle, sy, cy);
        q.quat_x = to_q14(prod3(sr, cp, cy) - prod3(cr, sp, sy));
        q.quat_y = to_q14(prod3(cr, sp, cy) + prod3(sr, cp, sy));
        q.quat_z = to_q14(prod3(cr, cp, sy) - prod3(sr, sp, cy));
        q.quat_w = to_q14(prod3(cr, cp, cy) + prod3(sr, sp, sy));
        return q;
    endfunction

    assign o_pending = quat_fifo.size();

    always @(posedge i_clk) begin
        t_quat exp_q;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_start && !i_busy) quat_fifo.push_back(euler_quat(i_angles));
            if (i_valid) begin
                if (quat_fifo.size() == 0) begin
                    $error("result beat with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_q = quat_fifo.pop_front();
                    if (exp_q !== i_quat) begin
                        if (exp_q.quat_x !== i_quat.quat_x)
                            $error("quat_x exp %0d got %0d", exp_q.quat_x, i_quat.quat_x);
                        if (exp_q.quat_y !== i_quat.quat_y)
                            $error("quat_y exp %0d got %0d", exp_q.quat_y, i_quat.quat_y);
                        if (exp_q.quat_z !== i_quat.quat_z)
                            $error("quat_z exp %0d got %0d", exp_q.quat_z, i_quat.quat_z);
                        if (exp_q.quat_w !== i_quat.quat_w)
                            $error("quat_w exp %0d got %0d", exp_q.quat_w, i_quat.quat_w);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import etq_pkg::*;

    localparam int LATENCY    = 37;
    localparam int WATCH_LIMIT = 2000;

    logic    i_clk = 0;
    logic    i_rst_n = 0;
    logic    start = 0;
    logic    busy;
    t_angles i_angles = '0;
    logic    o_valid;
    t_quat   o_quat;
    int      fail_count;
    int      pending;
    int      idle_cycles = 0;

    always #4 i_clk = ~i_clk;

    euler_to_quaternion_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_angles(i_angles),
        .o_valid (o_valid),
        .o_quat  (o_quat)
    );

    quat_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_angles    (i_angles),
        .i_valid     (o_valid),
        .i_quat      (o_quat),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Watchdog: count cycles with no beat on either channel.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Present one beat, hold it until accepted; leave start high for the next.
    task automatic send_beat(input t_angles a, input int idle_pct);
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start    <= 1'b1;
        i_angles <= a;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_angle();
        case ($urandom_range(5, 0))
            0: return 16'(16'sh8000 + $urandom_range(15, 0));
            1: return 16'(16'sh7fff - $urandom_range(15, 0));
            2: return 16'($urandom_range(20, 0) - 10);
            // near the fold points, where the half angle is +/- pi/2
            3: return 16'((($urandom_range(1, 0) ? 12868 : -12868) + $urandom_range(64, 0) - 32));
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        t_angles a;
        logic signed [15:0] edges[6];
        int phase_pct[4];
        edges = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001, 16'shffff, 16'sd12868};
        phase_pct = '{0, 79, 0, 12};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: each field at its extremes and around the fold.
        for (int i = 0; i < 6; i++) begin
            send_beat('{edges[i], 16'sh0000, 16'sh0000}, 0);
            send_beat('{16'sh0000, edges[i], 16'sh0000}, 0);
            send_beat('{16'sh0000, 16'sh0000, edges[i]}, 0);
            send_beat('{edges[i], edges[5 - i], edges[i]}, 0);
        end

        // Drain completely once before random traffic.
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        for (int ph = 0; ph < 4; ph++) begin
            for (int n = 0; n < 385; n++) begin
                a.roll_angle  = pick_angle();
                a.pitch_angle = pick_angle();
                a.yaw_angle   = pick_angle();
                send_beat(a, phase_pct[ph]);
            end
        end
        start <= 1'b0;
        @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
